### rtl/hbsr_pkg.sv
// Shared types and constants for the H-bridge soft ramp and reversal sequencer.
`timescale 1ns / 1ps

package hbsr_pkg;

    // Transaction kinds on the command channel
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_DRIVE = 2'd1,
        MODE_STOP  = 2'd2
    } mode_t;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_MIN_DUTY      = 3'd0;
    localparam logic [2:0] REG_MAX_DUTY      = 3'd1;
    localparam logic [2:0] REG_RAMP_STEP     = 3'd2;
    localparam logic [2:0] REG_RAMP_INTERVAL = 3'd3;
    localparam logic [2:0] REG_DEADTIME      = 3'd4;

    // Register reset values
    localparam logic [7:0]  MIN_DUTY_RST      = 8'd40;
    localparam logic [7:0]  MAX_DUTY_RST      = 8'd255;
    localparam logic [7:0]  RAMP_STEP_RST     = 8'd5;
    localparam logic [15:0] RAMP_INTERVAL_RST = 16'd10;
    localparam logic [15:0] DEADTIME_RST      = 16'd200;

    // Saturation value of the elapsed-time counter
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  min_duty;
        logic [7:0]  max_duty;
        logic [7:0]  step_size;
        logic [15:0] step_period;
        logic [15:0] deadtime_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       direction;
        logic [7:0] duty;
    } cmd_t;

    typedef struct packed {
        logic       right_enable;
        logic       left_enable;
        logic [7:0] right_duty;
        logic [7:0] left_duty;
        logic [7:0] applied_duty;
        logic       active_direction;
        logic       running;
        logic       reversal_pending;
    } res_t;

endpackage

### rtl/h_bridge_soft_ramp_reversal_top.sv
// Top level of the H-bridge soft ramp and reversal sequencer.
// A transaction accepted into the input register has its result loaded into the result
// register when that register is free or being emptied by the receiver.
// Throughput: one transaction per cycle while the result output is not stalled; the state
// update is a single pass between the input register and the result register.
// Reset: rst_n clears all drive state and valid flags and loads the register defaults.
`timescale 1ns / 1ps

module h_bridge_soft_ramp_reversal_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  hbsr_pkg::cmd_t      cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output hbsr_pkg::res_t      res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    hbsr_pkg::cfg_t cfg;
    hbsr_pkg::res_t core_res;

    logic           in_valid_reg, in_valid_next;
    hbsr_pkg::cmd_t in_item_reg;
    logic           res_valid_reg, res_valid_next;
    hbsr_pkg::res_t res_reg;
    logic           advance;
    logic           cmd_fire;

    hbsr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hbsr_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (in_item_reg),
        .fire   (advance),
        .result (core_res)
    );

    // Handshake: execute when the result register is free or being emptied
    assign advance   = in_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !advance;
    assign cmd_fire  = cmd_valid && !cmd_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (cmd_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
            in_item_reg <= cmd;
        if (advance)
            res_reg <= core_res;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### rtl/hbsr_regs.sv
// APB-style configuration registers of the H-bridge sequencer.
`timescale 1ns / 1ps

module hbsr_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output hbsr_pkg::cfg_t      cfg
);

    hbsr_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_duty    <= hbsr_pkg::MIN_DUTY_RST;
            cfg_reg.max_duty    <= hbsr_pkg::MAX_DUTY_RST;
            cfg_reg.step_size   <= hbsr_pkg::RAMP_STEP_RST;
            cfg_reg.step_period <= hbsr_pkg::RAMP_INTERVAL_RST;
            cfg_reg.deadtime_ms <= hbsr_pkg::DEADTIME_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                hbsr_pkg::REG_MIN_DUTY:      cfg_reg.min_duty <= pwdata[7:0];
                hbsr_pkg::REG_MAX_DUTY:      cfg_reg.max_duty <= pwdata[7:0];
                hbsr_pkg::REG_RAMP_STEP:     cfg_reg.step_size <= pwdata[7:0];
                hbsr_pkg::REG_RAMP_INTERVAL: cfg_reg.step_period <= pwdata[15:0];
                hbsr_pkg::REG_DEADTIME:      cfg_reg.deadtime_ms <= pwdata[15:0];
                default:                     ;
            endcase
        end
    end

    // Read data, zero extended
    always_comb
    begin
        case (reg_idx)
            hbsr_pkg::REG_MIN_DUTY:      prdata = {24'd0, cfg_reg.min_duty};
            hbsr_pkg::REG_MAX_DUTY:      prdata = {24'd0, cfg_reg.max_duty};
            hbsr_pkg::REG_RAMP_STEP:     prdata = {24'd0, cfg_reg.step_size};
            hbsr_pkg::REG_RAMP_INTERVAL: prdata = {16'd0, cfg_reg.step_period};
            hbsr_pkg::REG_DEADTIME:      prdata = {16'd0, cfg_reg.deadtime_ms};
            default:                     prdata = 32'd0;
        endcase
    end

endmodule

### rtl/hbsr_core.sv
// Drive state and single-pass update logic of the H-bridge sequencer.
`timescale 1ns / 1ps

module hbsr_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  hbsr_pkg::cfg_t      cfg,
    input  hbsr_pkg::cmd_t      item,
    input  logic                fire,
    output hbsr_pkg::res_t      result
);

    logic [7:0]  req_level_reg, req_level_next;
    logic [7:0]  applied_reg, applied_next;
    logic        req_side_reg, req_side_next;
    logic        active_side_reg, active_side_next;
    logic        running_reg, running_next;
    logic        pending_reg, pending_next;
    logic [15:0] dt_left_reg, dt_left_next;
    logic [15:0] since_reg, since_next;
    logic        right_en_reg, right_en_next;
    logic        left_en_reg, left_en_next;
    logic [7:0]  right_lvl_reg, right_lvl_next;
    logic [7:0]  left_lvl_reg, left_lvl_next;

    logic [7:0]  clamped;
    logic [15:0] since_inc;
    logic [15:0] dt_dec;
    logic [8:0]  up_sum;
    logic [7:0]  up_level;
    logic [7:0]  down_level;
    logic [7:0]  stepped;

    // Clamp of the commanded duty: raise to minimum first, then limit
    always_comb
    begin
        if (item.duty == 8'd0)
            clamped = 8'd0;
        else if (item.duty < cfg.min_duty)
            clamped = cfg.min_duty;
        else if (item.duty > cfg.max_duty)
            clamped = cfg.max_duty;
        else
            clamped = item.duty;
    end

    // Time base: saturating elapsed count and dead-time countdown
    assign since_inc = (since_reg == hbsr_pkg::CNT_MAX) ? since_reg : since_reg + 16'd1;
    assign dt_dec    = (dt_left_reg != 16'd0) ? dt_left_reg - 16'd1 : 16'd0;

    // One ramp step toward the requested level, without overshoot
    always_comb
    begin
        up_sum   = {1'b0, applied_reg} + {1'b0, cfg.step_size};
        up_level = (up_sum > {1'b0, req_level_reg}) ? req_level_reg : up_sum[7:0];
        if (applied_reg > cfg.step_size)
            down_level = applied_reg - cfg.step_size;
        else
            down_level = req_level_reg;
        if (down_level < req_level_reg)
            down_level = req_level_reg;
        if (applied_reg < req_level_reg)
            stepped = up_level;
        else if (applied_reg > req_level_reg)
            stepped = down_level;
        else
            stepped = applied_reg;
    end

    // Next state for the transaction in the input register
    always_comb
    begin
        req_level_next   = req_level_reg;
        applied_next     = applied_reg;
        req_side_next    = req_side_reg;
        active_side_next = active_side_reg;
        running_next     = running_reg;
        pending_next     = pending_reg;
        dt_left_next     = dt_left_reg;
        since_next       = since_reg;
        right_en_next    = right_en_reg;
        left_en_next     = left_en_reg;
        right_lvl_next   = right_lvl_reg;
        left_lvl_next    = left_lvl_reg;

        case (item.mode)
            hbsr_pkg::MODE_TICK:
            begin
                since_next   = since_inc;
                dt_left_next = dt_dec;
                if (req_level_reg != 8'd0 && !(pending_reg && dt_dec != 16'd0))
                begin
                    pending_next = 1'b0;
                    if (applied_reg == 8'd0 || since_inc >= cfg.step_period)
                    begin
                        applied_next = stepped;
                        since_next   = 16'd0;
                    end
                    active_side_next = req_side_reg;
                    running_next     = 1'b1;
                    right_en_next    = !req_side_reg;
                    left_en_next     = req_side_reg;
                    right_lvl_next   = req_side_reg ? 8'd0 : applied_next;
                    left_lvl_next    = req_side_reg ? applied_next : 8'd0;
                end
            end
            hbsr_pkg::MODE_DRIVE:
            begin
                if (clamped == 8'd0)
                begin
                    req_level_next = 8'd0;
                    applied_next   = 8'd0;
                    running_next   = 1'b0;
                    pending_next   = 1'b0;
                    right_en_next  = 1'b0;
                    left_en_next   = 1'b0;
                    right_lvl_next = 8'd0;
                    left_lvl_next  = 8'd0;
                end
                else
                begin
                    req_side_next  = item.direction;
                    req_level_next = clamped;
                    // Reversal while running: blank both sides and start dead time
                    if (running_reg && item.direction != active_side_reg && !pending_reg)
                    begin
                        applied_next   = 8'd0;
                        running_next   = 1'b0;
                        pending_next   = 1'b1;
                        dt_left_next   = cfg.deadtime_ms;
                        right_en_next  = 1'b0;
                        left_en_next   = 1'b0;
                        right_lvl_next = 8'd0;
                        left_lvl_next  = 8'd0;
                    end
                end
            end
            hbsr_pkg::MODE_STOP:
            begin
                req_level_next = 8'd0;
                applied_next   = 8'd0;
                running_next   = 1'b0;
                pending_next   = 1'b0;
                right_en_next  = 1'b0;
                left_en_next   = 1'b0;
                right_lvl_next = 8'd0;
                left_lvl_next  = 8'd0;
            end
            default:
            begin
            end
        endcase
    end

    // State registers, updated once per executed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_level_reg   <= 8'd0;
            applied_reg     <= 8'd0;
            req_side_reg    <= 1'b0;
            active_side_reg <= 1'b0;
            running_reg     <= 1'b0;
            pending_reg     <= 1'b0;
            dt_left_reg     <= 16'd0;
            since_reg       <= 16'd0;
            right_en_reg    <= 1'b0;
            left_en_reg     <= 1'b0;
            right_lvl_reg   <= 8'd0;
            left_lvl_reg    <= 8'd0;
        end
        else if (fire)
        begin
            req_level_reg   <= req_level_next;
            applied_reg     <= applied_next;
            req_side_reg    <= req_side_next;
            active_side_reg <= active_side_next;
            running_reg     <= running_next;
            pending_reg     <= pending_next;
            dt_left_reg     <= dt_left_next;
            since_reg       <= since_next;
            right_en_reg    <= right_en_next;
            left_en_reg     <= left_en_next;
            right_lvl_reg   <= right_lvl_next;
            left_lvl_reg    <= left_lvl_next;
        end
    end

    // Result reflects the state after the transaction
    always_comb
    begin
        result.right_enable     = right_en_next;
        result.left_enable      = left_en_next;
        result.right_duty       = right_lvl_next;
        result.left_duty        = left_lvl_next;
        result.applied_duty     = applied_next;
        result.active_direction = active_side_next;
        result.running          = running_next;
        result.reversal_pending = pending_next;
    end

`ifndef SYNTHESIS
    // The two half-bridges are never enabled together.
    a_no_shoot_through: assert property (@(posedge clk) disable iff (!rst_n)
        !(right_en_reg && left_en_reg))
        else $error("both half-bridges enabled");

    // Running exactly when one side is enabled.
    a_running_matches_pins: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg == (right_en_reg || left_en_reg))
        else $error("running flag disagrees with enable pins");

    // Dead time keeps the bridge off.
    a_pending_blanks: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (!running_reg && applied_reg == 8'd0))
        else $error("bridge driven during dead time");

    // A stop leaves nothing requested or driven.
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.mode == hbsr_pkg::MODE_STOP) |=>
            (req_level_reg == 8'd0 && !running_reg && !pending_reg))
        else $error("stop did not clear the drive state");
`endif

endmodule

### sim/h_bridge_soft_ramp_reversal_top_tb.sv
// Self-checking testbench for the H-bridge soft ramp and reversal sequencer.
`timescale 1ns / 1ps

module h_bridge_soft_ramp_reversal_top_tb;

    // Mode code that the block must ignore
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Cycles without any accepted transaction before the run is declared hung
    localparam int IDLE_LIMIT = 2000;
    // Length of the receiver hold-off in the back-pressure test
    localparam int HOLD_CYCLES = 60;
    // Cycles to wait after the last result has come back before touching registers
    localparam int SETTLE_CYCLES = 4;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cmd_valid;
    logic           cmd_stall;
    hbsr_pkg::cmd_t cmd;
    logic           res_valid;
    logic           res_stall;
    hbsr_pkg::res_t res;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [4:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    h_bridge_soft_ramp_reversal_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shared run state.
    hbsr_pkg::res_t drive_expect_q[$];
    int   error_count = 0;
    int   cmd_count   = 0;
    int   res_count   = 0;
    int   cfg_count   = 0;
    bit   idle_on     = 1'b1;
    bit   hold_request = 1'b0;

    // Predictor copy of the registers and the drive state.
    hbsr_pkg::cfg_t cur_cfg = '{hbsr_pkg::MIN_DUTY_RST, hbsr_pkg::MAX_DUTY_RST,
                                hbsr_pkg::RAMP_STEP_RST, hbsr_pkg::RAMP_INTERVAL_RST,
                                hbsr_pkg::DEADTIME_RST};
    logic [7:0]  want_lvl   = '0;
    logic [7:0]  ramp_lvl   = '0;
    logic        want_side  = 1'b0;
    logic        drive_side = 1'b0;
    logic        motor_on   = 1'b0;
    logic        blanking   = 1'b0;
    logic [15:0] dead_left  = '0;
    logic [15:0] since_step = '0;
    logic        right_on   = 1'b0;
    logic        left_on    = 1'b0;
    logic [7:0]  r_out_lvl  = '0;
    logic [7:0]  l_out_lvl  = '0;

    function automatic void blank_pins();
        right_on  = 1'b0;
        left_on   = 1'b0;
        r_out_lvl = '0;
        l_out_lvl = '0;
    endfunction

    function automatic void stop_motor();
        want_lvl = '0;
        ramp_lvl = '0;
        motor_on = 1'b0;
        blanking = 1'b0;
        blank_pins();
    endfunction

    // Apply one command to the predicted state and return the expected outputs.
    function automatic hbsr_pkg::res_t predict_drive(hbsr_pkg::cmd_t c);
        logic [7:0]     lvl;
        logic [8:0]     nxt;
        hbsr_pkg::res_t r;
        case (c.mode)
            hbsr_pkg::MODE_TICK:
            begin
                if (since_step != hbsr_pkg::CNT_MAX)
                    since_step = since_step + 16'd1;
                if (dead_left != 16'd0)
                    dead_left = dead_left - 16'd1;
                // Ramp only with a request and once any dead time has run out.
                if (want_lvl != 8'd0 && !(blanking && dead_left != 16'd0))
                begin
                    blanking = 1'b0;
                    if (ramp_lvl == 8'd0 || since_step >= cur_cfg.step_period)
                    begin
                        nxt = {1'b0, ramp_lvl} + {1'b0, cur_cfg.step_size};
                        if (ramp_lvl < want_lvl)
                            ramp_lvl = (nxt > {1'b0, want_lvl}) ? want_lvl : nxt[7:0];
                        else if (ramp_lvl > want_lvl)
                        begin
                            ramp_lvl = (ramp_lvl > cur_cfg.step_size) ?
                                       ramp_lvl - cur_cfg.step_size : want_lvl;
                            if (ramp_lvl < want_lvl)
                                ramp_lvl = want_lvl;
                        end
                        since_step = '0;
                    end
                    drive_side = want_side;
                    motor_on   = 1'b1;
                    right_on   = !drive_side;
                    left_on    = drive_side;
                    r_out_lvl  = drive_side ? 8'd0 : ramp_lvl;
                    l_out_lvl  = drive_side ? ramp_lvl : 8'd0;
                end
            end
            hbsr_pkg::MODE_DRIVE:
            begin
                // The raise to the minimum wins over the limit to the maximum.
                if (c.duty == 8'd0)
                    lvl = 8'd0;
                else if (c.duty < cur_cfg.min_duty)
                    lvl = cur_cfg.min_duty;
                else if (c.duty > cur_cfg.max_duty)
                    lvl = cur_cfg.max_duty;
                else
                    lvl = c.duty;
                if (lvl == 8'd0)
                    stop_motor();
                else
                begin
                    want_side = c.direction;
                    want_lvl  = lvl;
                    // Reversal while running blanks the bridge for the dead time.
                    if (motor_on && c.direction != drive_side && !blanking)
                    begin
                        blank_pins();
                        ramp_lvl  = '0;
                        motor_on  = 1'b0;
                        blanking  = 1'b1;
                        dead_left = cur_cfg.deadtime_ms;
                    end
                end
            end
            hbsr_pkg::MODE_STOP:
                stop_motor();
            default:
                ;
        endcase
        r.right_enable     = right_on;
        r.left_enable      = left_on;
        r.right_duty       = r_out_lvl;
        r.left_duty        = l_out_lvl;
        r.applied_duty     = ramp_lvl;
        r.active_direction = drive_side;
        r.running          = motor_on;
        r.reversal_pending = blanking;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // Send one command transaction and record its expected result on acceptance.
    task automatic send_cmd(logic [1:0] mode, logic dir, logic [7:0] duty);
        hbsr_pkg::cmd_t c;
        int             gap;
        c.mode      = mode;
        c.direction = dir;
        c.duty      = duty;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        drive_expect_q.push_back(predict_drive(c));
        cmd_count++;
        @(negedge clk);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_cmd(hbsr_pkg::MODE_TICK, 1'b0, 8'd0);
    endtask

    // Stop offering commands and wait until every result has come back.
    task automatic settle();
        cmd_valid <= 1'b0;
        while (drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register over APB, then read it back.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            hbsr_pkg::REG_MIN_DUTY:      cur_cfg.min_duty    = val[7:0];
            hbsr_pkg::REG_MAX_DUTY:      cur_cfg.max_duty    = val[7:0];
            hbsr_pkg::REG_RAMP_STEP:     cur_cfg.step_size   = val[7:0];
            hbsr_pkg::REG_RAMP_INTERVAL: cur_cfg.step_period = val[15:0];
            hbsr_pkg::REG_DEADTIME:      cur_cfg.deadtime_ms = val[15:0];
            default:                     ;
        endcase
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== val)
        begin
            $error("register %0d readback mismatch: expected %0h, actual %0h",
                   idx, val, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Load a full register setting while the block is idle.
    task automatic program_regs(logic [7:0] min_d, logic [7:0] max_d, logic [7:0] step,
                                logic [15:0] interval, logic [15:0] dead);
        settle();
        write_reg(hbsr_pkg::REG_MIN_DUTY,      {24'd0, min_d});
        write_reg(hbsr_pkg::REG_MAX_DUTY,      {24'd0, max_d});
        write_reg(hbsr_pkg::REG_RAMP_STEP,     {24'd0, step});
        write_reg(hbsr_pkg::REG_RAMP_INTERVAL, {16'd0, interval});
        write_reg(hbsr_pkg::REG_DEADTIME,      {16'd0, dead});
        cfg_count++;
    endtask

    // Reset register values: unused mode, clamp to the minimum, slow ramp, stop by zero.
    task automatic test_defaults();
        send_cmd(MODE_UNUSED, 1'b1, 8'hFF);
        send_ticks(1);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b0, 8'd1);
        send_ticks(4);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b0, 8'd255);
        send_ticks(2);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b1, 8'd0);
    endtask

    // Clamp order, zero dead time and a limit to zero.
    task automatic test_clamp();
        program_regs(8'd200, 8'd50, 8'd255, 16'd0, 16'd0);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b0, 8'd10);
        send_ticks(1);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b1, 8'd255);
        send_ticks(2);
        send_cmd(hbsr_pkg::MODE_STOP, 1'b0, 8'd0);
        program_regs(8'd0, 8'd0, 8'd5, 16'd1, 16'd4);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b1, 8'd77);
        send_ticks(1);
        program_regs(8'd0, 8'd255, 8'd5, 16'd1, 16'd4);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b0, 8'd1);
        send_ticks(2);
    endtask

    // A zero ramp step keeps the duty at zero while the side is still enabled.
    task automatic test_zero_step();
        program_regs(8'd40, 8'd255, 8'd0, 16'd3, 16'd2);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b0, 8'd100);
        send_ticks(3);
        send_cmd(hbsr_pkg::MODE_STOP, 1'b1, 8'd0);
    endtask

    // Reversal, a new command during dead time, then a ramp down.
    task automatic test_reversal();
        program_regs(8'd10, 8'd200, 8'd7, 16'd2, 16'd3);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b0, 8'd30);
        send_ticks(4);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b1, 8'd50);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b0, 8'd60);
        send_ticks(5);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b0, 8'd15);
        send_ticks(4);
    endtask

    // Largest dead time and ramp interval, run back to back without idling.
    task automatic test_long_counts();
        program_regs(8'd40, 8'd255, 8'd5, 16'hFFFF, 16'hFFFF);
        idle_on = 1'b0;
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b0, 8'd200);
        send_ticks(3);
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b1, 8'd200);
        send_ticks(30);
        // A further command during the dead time does not restart it.
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b0, 8'd90);
        send_ticks(10);
        idle_on = 1'b1;
        send_cmd(hbsr_pkg::MODE_STOP, 1'b0, 8'd0);
    endtask

    // Receiver holds off for a long stretch while commands keep coming.
    task automatic test_backpressure();
        program_regs(8'd20, 8'd180, 8'd9, 16'd1, 16'd2);
        idle_on      = 1'b0;
        hold_request = 1'b1;
        send_cmd(hbsr_pkg::MODE_DRIVE, 1'b1, 8'd120);
        repeat (40)
            send_cmd(($urandom_range(0, 3) == 0) ? hbsr_pkg::MODE_DRIVE : hbsr_pkg::MODE_TICK,
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        idle_on = 1'b1;
    endtask

    // One random item, mostly ticks and drive commands.
    task automatic send_random_item();
        int         pick;
        logic [7:0] duty;
        pick = $urandom_range(0, 99);
        duty = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        if (pick < 60)
            send_cmd(hbsr_pkg::MODE_TICK, 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
        else if (pick < 86)
            send_cmd(hbsr_pkg::MODE_DRIVE, 1'($urandom_range(0, 1)), duty);
        else if (pick < 96)
            send_cmd(hbsr_pkg::MODE_STOP, 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)));
        else
            send_cmd(MODE_UNUSED, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // Random register settings and random command streams.
    task automatic test_random();
        logic [7:0] min_d;
        logic [7:0] max_d;
        logic [7:0] step;
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                program_regs(8'd255, 8'd255, 8'd255, 16'd0, 16'd0);
            else if (phase == 1)
                program_regs(8'd0, 8'd0, 8'd1, 16'd0, 16'd1);
            else
            begin
                min_d = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 60));
                max_d = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(100, 255));
                step  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                    : 8'($urandom_range(1, 20));
                program_regs(min_d, max_d, step, 16'($urandom_range(0, 6)),
                             16'($urandom_range(0, 12)));
            end
            // One phase runs with no idling on either side.
            idle_on = (phase != 4);
            repeat (60) send_random_item();
            idle_on = 1'b1;
        end
    endtask

    // Result receiver: random stall per transaction plus the requested hold-off.
    initial
    begin : result_receiver
        int waits;
        res_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            waits = idle_on ? $urandom_range(0, 7) : 0;
            if (hold_request)
            begin
                waits        = waits + HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (waits > 0)
            begin
                res_stall <= 1'b1;
                repeat (waits) @(negedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!(res_valid && !res_stall))
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        hbsr_pkg::res_t exp_r;
        if (rst_n && res_valid && !res_stall)
        begin
            res_count++;
            if (drive_expect_q.size() == 0)
            begin
                $error("result arrived with no command outstanding");
                error_count++;
            end
            else
            begin
                exp_r = drive_expect_q.pop_front();
                compare_field("right_enable", 8'(exp_r.right_enable),
                              8'(res.right_enable));
                compare_field("left_enable", 8'(exp_r.left_enable),
                              8'(res.left_enable));
                compare_field("right_duty",       exp_r.right_duty,       res.right_duty);
                compare_field("left_duty",        exp_r.left_duty,        res.left_duty);
                compare_field("applied_duty",     exp_r.applied_duty,     res.applied_duty);
                compare_field("active_direction", 8'(exp_r.active_direction),
                              8'(res.active_direction));
                compare_field("running", 8'(exp_r.running), 8'(res.running));
                compare_field("reversal_pending", 8'(exp_r.reversal_pending),
                              8'(res.reversal_pending));
            end
        end
    end

    // Watchdog on cycles in which nothing moves on any port.
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) || psel)
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin : test_sequence
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_defaults();
        test_clamp();
        test_zero_step();
        test_reversal();
        test_long_counts();
        test_backpressure();
        test_random();

        settle();
        repeat (10) @(posedge clk);
        if (drive_expect_q.size() != 0)
        begin
            $error("%0d expected results never arrived", drive_expect_q.size());
            error_count++;
        end
        $display("Checked %0d results for %0d commands over %0d register settings,",
                 res_count, cmd_count, cfg_count);
        $display("including clamp corners, reversals, long dead times and hold-off.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
